### hdl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared constants and types for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned CAPACITY = 8;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // One slot as seen by its neighbors.
  typedef struct packed {
    logic               vld;
    logic signed [31:0] val;
  } slot_t;

  // Command broadcast to every cell.
  typedef struct packed {
    logic               ins;
    logic               del;
    logic signed [31:0] value;
  } cell_cmd_t;

endpackage

### hdl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: shifts right on insert, left on delete.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_cmd_t cmd_i,
  input  slot_t     left_i,       // lower neighbor
  input  logic      take_left_i,  // lower neighbor moves on insert
  input  slot_t     right_i,      // upper neighbor
  output slot_t     slot_o,
  output logic      take_o
);

  logic               vld_q, vld_d;
  logic signed [31:0] val_q, val_d;

  // This slot is at or past the insert point.
  assign take_o = !vld_q || (val_q > cmd_i.value);

  always_comb begin
    vld_d = vld_q;
    val_d = val_q;
    if (cmd_i.ins) begin
      if (take_o && !take_left_i) begin
        vld_d = 1'b1;
        val_d = cmd_i.value;
      end else if (take_o) begin
        vld_d = left_i.vld;
        val_d = left_i.val;
      end
    end else if (cmd_i.del) begin
      vld_d = right_i.vld;
      val_d = right_i.val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign slot_o.vld = vld_q;
  assign slot_o.val = val_q;

endmodule

### hdl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Ascending priority queue kept as a chain of sorted slot cells.
// ----------------------------------------------------------------------------
// The result strobe done_o rises in the cycle after start is taken.
// Throughput: one request per cycle; busy stays low, every cell compares
//   against the broadcast value and shifts in the same cycle.
// Reset: all slot valid bits and the result strobe clear; the queue is empty.
// The receiver cannot stall: each result is shown for exactly one cycle.
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode_i,
  input  logic signed [31:0] value_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic signed [31:0] removed_value_o,
  output logic               is_empty_o
);

  slot_t                slot   [CAPACITY];
  slot_t                right  [CAPACITY];
  logic  [CAPACITY-1:0] take;
  logic  [CAPACITY-1:0] vld_vec;
  cell_cmd_t            cmd;
  logic                 req;
  logic                 is_ins, is_del;
  logic                 empty, full;

  // Result registers
  logic               done_q;
  logic [1:0]         status_q, status_d;
  logic signed [31:0] removed_q, removed_d;
  logic               is_empty_q, is_empty_d;

  // Every request is taken as it comes.
  assign busy = 1'b0;
  assign req  = start && !busy;

  assign empty  = !slot[0].vld;
  assign full   = slot[CAPACITY-1].vld;
  assign is_ins = req && (mode_i == MODE_INSERT);
  assign is_del = req && (mode_i == MODE_DELETE);

  // Full insert and empty delete leave the chain alone.
  assign cmd.ins   = is_ins && !full;
  assign cmd.del   = is_del && !empty;
  assign cmd.value = value_i;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    slot_t left_s;
    logic  take_left_s;

    if (i == 0) begin : g_head
      assign left_s      = '0;
      assign take_left_s = 1'b0;
    end else begin : g_body
      assign left_s      = slot[i-1];
      assign take_left_s = take[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right[i] = '0;
    end else begin : g_link
      assign right[i] = slot[i+1];
    end

    assign vld_vec[i] = slot[i].vld;

    spq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .left_i      (left_s),
      .take_left_i (take_left_s),
      .right_i     (right[i]),
      .slot_o      (slot[i]),
      .take_o      (take[i])
    );
  end

  // Result for this request, computed from the chain before it moves.
  always_comb begin
    status_d   = ST_DONE;
    removed_d  = '0;
    is_empty_d = empty;
    if (is_ins) begin
      if (full) begin
        status_d = ST_FULL;
      end else begin
        is_empty_d = 1'b0;
      end
    end else if (is_del) begin
      if (empty) begin
        status_d = ST_EMPTY;
      end else begin
        removed_d  = slot[0].val;
        is_empty_d = !right[0].vld;  // second slot empty -> nothing left
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= req;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req) begin
      status_q   <= status_d;
      removed_q  <= removed_d;
      is_empty_q <= is_empty_d;
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign removed_value_o = removed_q;
  assign is_empty_o      = is_empty_q;

  // Assertions
  a_done_follows_req : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req |=> done_o) else $error("request without result strobe");

  a_vld_contiguous : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((vld_vec + 1'b1) & vld_vec) == '0) else $error("slot valid bits not packed");

  a_full_not_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_FULL) |-> !is_empty_o)
    else $error("full status with empty flag");

  a_empty_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_EMPTY) |-> (is_empty_o && removed_value_o == '0))
    else $error("empty delete result inconsistent");

  a_empty_matches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (is_empty_o == !slot[0].vld))
    else $error("empty flag disagrees with chain");

endmodule
